// ----- design/segred_pkg.sv -----
// Package for the segmented reduction block: field widths, mode codes, defaults.
// Used by segmented_reduction; depends on nothing else.
package segred_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW  = 16;
  localparam int unsigned LenW  = 17;
  localparam int unsigned ModeW = 3;

  localparam int unsigned SEGRED_MAX_SEGMENT = 65536;
  // position counter reach: 16 bits give 65536 elements
  localparam int unsigned PosReach = 65536;

  localparam logic [ModeW-1:0] MODE_MAX    = 3'd0;
  localparam logic [ModeW-1:0] MODE_MIN    = 3'd1;
  localparam logic [ModeW-1:0] MODE_SUM    = 3'd2;
  localparam logic [ModeW-1:0] MODE_MEAN   = 3'd3;
  localparam logic [ModeW-1:0] MODE_ARGMAX = 3'd4;
  localparam logic [ModeW-1:0] MODE_ARGMIN = 3'd5;

  localparam logic REG_OP_MODE = 1'b0;
  localparam logic REG_SEG_LEN = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ACC  = 6'b000010,
    ST_ABS  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_NEG  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_e;

endpackage

// ----- design/segmented_reduction.sv -----
// Segmented max/min/sum/mean/argmax/argmin reduction over a 32-bit signed stream.
// An element ending a segment passes through accumulate, then finish, where its result is
// registered; in mean mode sign fix, 32 restoring divide steps and quotient sign fix come between.
// A new element is taken only in idle, once the previous one is done and its result has reached
// a free output register; all work runs through one 33-bit add/subtract unit.
// Reset (async, active low): op_mode 0, segment_length 1, empty segment, no result.
module segmented_reduction
  import segred_pkg::*;
#(
  parameter int unsigned MAX_SEGMENT = SEGRED_MAX_SEGMENT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // stream in
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [DataW-1:0]    s_axis_tdata,   // [31:0] element_value
  input  logic                s_axis_tlast,   // last_of_tensor
  // stream out
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [47:0]         m_axis_tdata,   // [31:0] reduced_value, [47:32] best_index
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned CapInt = (MAX_SEGMENT < PosReach) ? MAX_SEGMENT : PosReach;
  localparam logic [LenW-1:0] LenCap = LenW'(CapInt);
  localparam int unsigned DivSteps = DataW;
  localparam int unsigned CntW = $clog2(DivSteps);
  localparam int unsigned UnitW = DataW + 1;

  // ---------------- registers ----------------
  logic [ModeW-1:0] op_mode_q;
  logic [LenW-1:0]  seg_len_q;
  state_e           state_q, state_d;
  logic [DataW-1:0] elem_q;
  logic             last_q;
  logic [DataW-1:0] run_q, run_d;
  logic [IdxW-1:0]  best_q, best_d;
  logic [IdxW-1:0]  pos_q, pos_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [IdxW-1:0]  rem_q, rem_d;
  logic             neg_q, neg_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic [47:0]      out_data_q, out_data_d;

  // ---------------- register port ----------------
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_mode_q <= MODE_MAX;
      seg_len_q <= LenW'(1);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_OP_MODE: op_mode_q <= pwdata[ModeW-1:0];
        REG_SEG_LEN: seg_len_q <= pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_OP_MODE: prdata = {{(32-ModeW){1'b0}}, op_mode_q};
      REG_SEG_LEN: prdata = {{(32-LenW){1'b0}}, seg_len_q};
      default:     prdata = '0;
    endcase
  end

  // ---------------- decoded configuration ----------------
  logic [ModeW-1:0] mode;
  logic [LenW-1:0]  len_eff;
  logic             is_sum, is_mean, is_arg, is_minlike;

  assign mode = (op_mode_q > MODE_ARGMIN) ? MODE_MAX : op_mode_q;

  always_comb begin
    len_eff = seg_len_q;
    if (len_eff == '0) len_eff = LenW'(1);
    if (len_eff > LenCap) len_eff = LenCap;
  end

  assign is_sum     = (mode == MODE_SUM) || (mode == MODE_MEAN);
  assign is_mean    = (mode == MODE_MEAN);
  assign is_arg     = (mode == MODE_ARGMAX) || (mode == MODE_ARGMIN);
  assign is_minlike = (mode == MODE_MIN) || (mode == MODE_ARGMIN);

  // ---------------- shared add/subtract unit ----------------
  logic [UnitW-1:0] op_a, op_b, unit_res;
  logic             op_sub;
  assign unit_res = op_a + (op_b ^ {UnitW{op_sub}}) + UnitW'(op_sub);

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b1;
    unique case (state_q)
      ST_ACC: begin
        if (is_sum) begin
          op_a   = {run_q[DataW-1], run_q};
          op_b   = {elem_q[DataW-1], elem_q};
          op_sub = 1'b0;
        end else if (is_minlike) begin
          // negative when element < running value
          op_a = {elem_q[DataW-1], elem_q};
          op_b = {run_q[DataW-1], run_q};
        end else begin
          // negative when running value < element
          op_a = {run_q[DataW-1], run_q};
          op_b = {elem_q[DataW-1], elem_q};
        end
      end
      ST_ABS: op_b = {run_q[DataW-1], run_q};
      ST_DIV: begin
        op_a = {{(UnitW-IdxW-1){1'b0}}, rem_q, quo_q[DataW-1]};
        op_b = {{(UnitW-LenW){1'b0}}, len_eff};
      end
      ST_NEG: op_b = {1'b0, quo_q};
      default: ;
    endcase
  end

  // ---------------- sequencer ----------------
  logic             in_acc, out_acc, better, seg_end, borrow;
  logic [LenW-1:0]  pos_next;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_acc       = out_valid_q & m_axis_tready;
  assign better        = unit_res[UnitW-1];
  assign borrow        = unit_res[UnitW-1];
  assign pos_next      = {1'b0, pos_q} + LenW'(1);
  assign seg_end       = (pos_next >= len_eff) || last_q;

  always_comb begin
    state_d     = state_q;
    run_d       = run_q;
    best_d      = best_q;
    pos_d       = pos_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    out_valid_d = out_acc ? 1'b0 : out_valid_q;
    out_data_d  = out_data_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_ACC;
      ST_ACC: begin
        if (pos_q == '0) begin
          run_d  = elem_q;
          best_d = '0;
        end else if (is_sum) begin
          run_d = unit_res[DataW-1:0];
        end else if (better) begin
          run_d = elem_q;
          if (is_arg) best_d = pos_q;
        end
        if (seg_end) begin
          pos_d   = '0;
          state_d = is_mean ? ST_ABS : ST_FIN;
        end else begin
          pos_d   = pos_next[IdxW-1:0];
          state_d = ST_IDLE;
        end
      end
      ST_ABS: begin
        neg_d   = run_q[DataW-1];
        quo_d   = run_q[DataW-1] ? unit_res[DataW-1:0] : run_q;
        rem_d   = '0;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // restoring step: remainder stays below the divisor, so 16 bits hold it
        rem_d = borrow ? {rem_q[IdxW-2:0], quo_q[DataW-1]} : unit_res[IdxW-1:0];
        quo_d = {quo_q[DataW-2:0], ~borrow};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(DivSteps - 1)) state_d = ST_NEG;
      end
      ST_NEG: begin
        if (neg_q) quo_d = unit_res[DataW-1:0];
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {(is_arg ? best_q : IdxW'(0)), (is_mean ? quo_q : run_q)};
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_q       <= '0;
      best_q      <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      best_q      <= best_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      elem_q <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    neg_q      <= neg_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
  a_accept_goes_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_ACC)
    else $error("accepted element not processed next cycle");

  a_rem_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> {1'b0, rem_q} < len_eff)
    else $error("divider remainder not below segment length");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == CntW'(DivSteps - 1)) |=> state_q == ST_NEG)
    else $error("divider did not finish after its last step");

  a_index_only_arg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[47:32] != '0) |-> is_arg)
    else $error("nonzero best index outside argmax/argmin");

  a_fin_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_valid_q && !m_axis_tready) |=> state_q == ST_FIN)
    else $error("pending result overwritten");
`endif

endmodule

// ----- tb/tb_segmented_reduction.sv -----
// Testbench for segmented_reduction: drives elements and register writes, predicts
// each segment result in place and checks the output stream. Depends on segred_pkg.
module tb_segmented_reduction;
  import segred_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned SettleCycles = 48;  // covers the mean divider after the last element
  localparam logic [DataW-1:0] ValMin = 32'h8000_0000;
  localparam logic [DataW-1:0] ValMax = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic [IdxW-1:0]  index;
  } seg_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [DataW-1:0] s_axis_tdata = '0;    // [31:0] element_value
  logic             s_axis_tlast = 1'b0;  // last_of_tensor
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [47:0]      m_axis_tdata;         // [31:0] reduced_value, [47:32] best_index
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [2:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  segmented_reduction u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // predictor state: configuration and the open segment
  logic [ModeW-1:0] cfg_mode = MODE_MAX;
  logic [LenW-1:0]  cfg_len = 17'd1;
  logic [DataW-1:0] acc_val = '0;
  logic [IdxW-1:0]  acc_best = '0;
  logic [IdxW-1:0]  acc_pos = '0;

  seg_result_t pending_results[$];
  seg_result_t seen_result;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  task automatic note_mismatch(input string what, input logic [47:0] exp_v,
                               input logic [47:0] act_v);
    if (mismatches < 10)
      $display("mismatch %s: expected %h actual %h at cycle %0d", what, exp_v, act_v,
               cycle_count);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result", '0, m_axis_tdata);
      end else begin
        seen_result = pending_results.pop_front();
        if (m_axis_tdata[31:0] !== seen_result.value)
          note_mismatch("reduced_value", 48'(seen_result.value), 48'(m_axis_tdata[31:0]));
        if (m_axis_tdata[47:32] !== seen_result.index)
          note_mismatch("best_index", 48'(seen_result.index), 48'(m_axis_tdata[47:32]));
      end
    end
  end

  // fold one accepted element into the open segment; queue a result when it closes
  task automatic fold_element(input logic [DataW-1:0] v, input logic last);
    logic [ModeW-1:0] mode;
    int unsigned      span;
    int unsigned      nxt;
    longint           quot;
    seg_result_t      res;
    mode = (cfg_mode > MODE_ARGMIN) ? MODE_MAX : cfg_mode;
    span = cfg_len;
    if (span == 0) span = 1;
    if (span > SEGRED_MAX_SEGMENT) span = SEGRED_MAX_SEGMENT;
    if (span > PosReach) span = PosReach;
    if (acc_pos == 0) begin
      acc_val = v;
      acc_best = '0;
    end else begin
      case (mode)
        MODE_MIN: begin
          if ($signed(v) < $signed(acc_val)) acc_val = v;
        end
        MODE_SUM, MODE_MEAN: begin
          acc_val = acc_val + v;
        end
        MODE_ARGMAX: begin
          if ($signed(v) > $signed(acc_val)) begin
            acc_val = v;
            acc_best = acc_pos;
          end
        end
        MODE_ARGMIN: begin
          if ($signed(v) < $signed(acc_val)) begin
            acc_val = v;
            acc_best = acc_pos;
          end
        end
        default: begin
          if ($signed(v) > $signed(acc_val)) acc_val = v;
        end
      endcase
    end
    nxt = acc_pos + 1;
    if (nxt >= span || last) begin
      res.value = acc_val;
      res.index = '0;
      if (mode == MODE_MEAN) begin
        quot = longint'($signed(acc_val)) / longint'(span);
        res.value = quot[31:0];
      end
      if (mode == MODE_ARGMAX || mode == MODE_ARGMIN) res.index = acc_best;
      pending_results.push_back(res);
      acc_pos = '0;
    end else begin
      acc_pos = nxt[IdxW-1:0];
    end
  endtask

  task automatic send_element(input logic [DataW-1:0] v, input logic last);
    @(negedge clk_i);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = v;
    s_axis_tlast = last;
    do @(posedge clk_i); while (!s_axis_tready);
    fold_element(v, last);
  endtask

  // stop sending and wait until every queued result is out and the block is quiet
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] readback;
    drain();
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_OP_MODE) cfg_mode = value[ModeW-1:0];
    else cfg_len = value[LenW-1:0];
    @(negedge clk_i);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = (idx == REG_OP_MODE) ? 32'(cfg_mode) : 32'(cfg_len);
    if (prdata !== readback) note_mismatch("register readback", 48'(readback), 48'(prdata));
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // every mode, the undefined codes too, on the most negative and most positive values
  task automatic test_mode_extremes();
    write_reg(REG_SEG_LEN, 32'd2);
    for (int i = 0; i < 8; i++) begin
      write_reg(REG_OP_MODE, 32'(i));
      send_element(ValMin, 1'b0);
      send_element(ValMax, 1'b0);
    end
  endtask

  task automatic test_zero_length();
    write_reg(REG_OP_MODE, 32'(MODE_SUM));
    write_reg(REG_SEG_LEN, 32'd0);
    send_element(32'h1234_5678, 1'b0);
  endtask

  // length register above the counter reach; the segment is closed by tlast
  task automatic test_oversized_length();
    write_reg(REG_OP_MODE, 32'(MODE_MEAN));
    write_reg(REG_SEG_LEN, 32'h0001_FFFF);
    send_element(ValMin, 1'b0);
    send_element(32'hFFFF_FFFF, 1'b1);
  endtask

  // -6 / 5 must truncate toward zero
  task automatic test_partial_mean();
    write_reg(REG_SEG_LEN, 32'd5);
    send_element(-32'sd7, 1'b0);
    send_element(32'd3, 1'b0);
    send_element(-32'sd2, 1'b1);
  endtask

  // shrink the length below the open position; the next element closes the segment
  task automatic test_midsegment_reconfig();
    write_reg(REG_OP_MODE, 32'(MODE_ARGMAX));
    write_reg(REG_SEG_LEN, 32'd4);
    send_element(32'd9, 1'b0);
    send_element(32'd11, 1'b0);
    send_element(32'd11, 1'b0);
    write_reg(REG_SEG_LEN, 32'd2);
    send_element(32'd40, 1'b0);
  endtask

  task automatic test_random_phase(input int unsigned count, input int unsigned sender_idle,
                                   input int unsigned recv_stall);
    int unsigned sent;
    int unsigned batch;
    int unsigned last_pct;
    int unsigned pick;
    logic [31:0] mode_word;
    logic [31:0] len_word;
    logic [DataW-1:0] v;
    idle_pct = sender_idle;
    stall_pct = recv_stall;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(9);
      mode_word = (pick > 7) ? 32'($urandom_range(5)) : 32'(pick);
      if ($urandom_range(3) == 0) mode_word = ($urandom & ~32'h7) | mode_word;
      pick = $urandom_range(99);
      if (pick < 55) len_word = 32'($urandom_range(1, 6));
      else if (pick < 80) len_word = 32'($urandom_range(7, 40));
      else if (pick < 87) len_word = 32'($urandom_range(41, 300));
      else if (pick < 92) len_word = 32'd0;
      else len_word = 32'($urandom_range(32'h1_0000, 32'h1_FFFF));
      if ($urandom_range(3) == 0) len_word = ($urandom & ~32'h1_FFFF) | len_word;
      last_pct = (len_word[LenW-1:0] > 17'd40) ? 20 : 8;
      if ($urandom_range(1)) begin
        write_reg(REG_OP_MODE, mode_word);
        write_reg(REG_SEG_LEN, len_word);
      end else begin
        write_reg(REG_SEG_LEN, len_word);
        write_reg(REG_OP_MODE, mode_word);
      end
      batch = $urandom_range(20, 60);
      if (batch > count - sent) batch = count - sent;
      for (int k = 0; k < batch; k++) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          v = $urandom;
        end else if (pick < 75) begin
          v = 32'($urandom_range(8)) - 32'd4;  // narrow range so ties are common
        end else begin
          case ($urandom_range(5))
            0: v = ValMin;
            1: v = ValMax;
            2: v = '0;
            3: v = '1;
            4: v = ValMin + 32'd1;
            default: v = ValMax - 32'd1;
          endcase
        end
        send_element(v, $urandom_range(99) < last_pct);
      end
      sent += batch;
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    test_mode_extremes();
    test_zero_length();
    test_oversized_length();
    test_partial_mean();
    test_midsegment_reconfig();
    test_random_phase(360, 0, 0);
    test_random_phase(360, 84, 0);
    test_random_phase(360, 0, 84);
    test_random_phase(370, 38, 38);
    drain();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/segred_pkg.sv
design/segmented_reduction.sv
tb/tb_segmented_reduction.sv
